### hdl/alpha_blend_line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Alpha blend line rasterizer assertion macros
// Assertion wrappers shared by the rasterizer modules. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_LINE_RASTERIZER_ASSERT_SVH
`define ALPHA_BLEND_LINE_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked with reset as a disable condition.
`define ABLR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ABLR_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABLR_ASSERT(label, clk, rst_n, prop, msg)
`define ABLR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### hdl/ablr_pkg.sv
// ----------------------------------------------------------------------------
// Alpha blend line rasterizer package
// Command codes, controller states, control and status bundles and the
// per-channel blend function.
// ----------------------------------------------------------------------------
package ablr_pkg;

    localparam int COORD_W = 11;
    localparam int WALK_W  = 13;
    localparam int ERR_W   = 16;
    localparam int CNT_W   = 12;
    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int LUMA_W  = 11;

    localparam logic [PIX_W-1:0]  GREY_LIGHT = 24'hC0C0C0;
    localparam logic [PIX_W-1:0]  GREY_DARK  = 24'h404040;
    localparam logic [LUMA_W-1:0] LUMA_LIMIT = 11'd512;
    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_NONE = 8'd0;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_XOR   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PRD,
        S_PWR,
        S_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_pix;
        logic wr_pix;
        logic clr_step;
        logic load_result;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic last_step;
    } t_sts;

    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] c,
                                                     input logic [CHAN_W-1:0] old);
        logic [2*CHAN_W-1:0] p_new;
        logic [2*CHAN_W-1:0] p_old;
        logic [2*CHAN_W:0]   acc;
        p_new = (2*CHAN_W)'(a) * (2*CHAN_W)'(c);
        p_old = (2*CHAN_W)'(ALPHA_FULL - a) * (2*CHAN_W)'(old);
        acc   = (2*CHAN_W+1)'(p_new) + (2*CHAN_W+1)'(p_old);
        return acc[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

### hdl/ablr_ctrl.sv
// ----------------------------------------------------------------------------
// Alpha blend line rasterizer controller
// Sequences the clearing pass, the per-pixel read and write of a line walk,
// the pixel read and the hand-over of each result to the output register.
// ----------------------------------------------------------------------------
`include "alpha_blend_line_rasterizer_assert.svh"

module ablr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_opcode,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ablr_pkg::t_sts  i_sts,
    output ablr_pkg::t_cmd  o_cmd
);
    import ablr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_from_cmd;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_from_cmd  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_from_cmd <= (t_op'(i_opcode) == OP_CLEAR);
            end
            if (o_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                // The clearing pass after reset returns to idle; a clear
                // request still owes its result.
                if (i_sts.clr_last) begin
                    n_state = r_from_cmd ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_op'(i_opcode))
                        OP_DRAW, OP_XOR: n_state = S_PRD;
                        OP_READ:         n_state = S_RD;
                        OP_CLEAR:        n_state = S_CLEAR;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_PRD: n_state = S_PWR;
            S_PWR: begin
                if (i_sts.last_step) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_RD: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PRD:   o_cmd.rd_pix = 1'b1;
            S_PWR:   o_cmd.wr_pix = 1'b1;
            S_RD:    o_cmd.rd_pix = 1'b1;
            S_DONE:  o_cmd.load_result = out_free;
            default: o_cmd = '0;
        endcase
    end

    `ABLR_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> (r_state == S_CLEAR && !o_out_valid), "reset must start the clearing pass with no result pending")
    `ABLR_ASSERT(a_write_after_read, i_clk, i_rst_n, (r_state == S_PWR) |-> ($past(r_state) == S_PRD), "pixel write without a preceding read")
    `ABLR_ASSERT(a_result_shown, i_clk, i_rst_n, o_cmd.load_result |=> o_out_valid, "loaded result not presented")

endmodule

### hdl/ablr_dpath.sv
// ----------------------------------------------------------------------------
// Alpha blend line rasterizer datapath
// Frame store memory, line walker, blend and grey-mark logic, clear address
// counter and the result register.
// ----------------------------------------------------------------------------
module ablr_dpath #(
    parameter int FB_WIDTH  = 256,
    parameter int FB_HEIGHT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ablr_pkg::t_cmd      i_cmd,
    output ablr_pkg::t_sts      o_sts,
    input  logic [1:0]          i_opcode,
    input  logic signed [10:0]  i_start_x,
    input  logic signed [10:0]  i_start_y,
    input  logic signed [10:0]  i_end_x,
    input  logic signed [10:0]  i_end_y,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic [7:0]          i_alpha,
    output logic [23:0]         o_read_value,
    output logic [11:0]         o_pixels_touched
);
    import ablr_pkg::*;

    localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    t_op                       r_op;
    logic [CHAN_W-1:0]         r_red;
    logic [CHAN_W-1:0]         r_green;
    logic [CHAN_W-1:0]         r_blue;
    logic [CHAN_W-1:0]         r_alpha;
    logic signed [WALK_W-1:0]  r_walk_x;
    logic signed [WALK_W-1:0]  r_walk_y;
    logic [ERR_W-1:0]          r_err;
    logic [ERR_W-1:0]          r_major4;
    logic [ERR_W-1:0]          r_minor4;
    logic [CNT_W-1:0]          r_steps;
    logic                      r_steep;
    logic                      r_sx_neg;
    logic                      r_sy_neg;
    logic [CNT_W-1:0]          r_count;
    logic [AW-1:0]             r_clr_addr;
    logic [PIX_W-1:0]          r_read_value;
    logic [CNT_W-1:0]          r_touched;

    // Set-up of a new line, straight from the request fields.
    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    logic [COORD_W:0]          init_dx;
    logic [COORD_W:0]          init_dy;
    logic                      init_steep;
    logic [COORD_W:0]          init_major;
    logic [COORD_W:0]          init_minor;

    assign diff_x     = (COORD_W+1)'(i_start_x) - (COORD_W+1)'(i_end_x);
    assign diff_y     = (COORD_W+1)'(i_start_y) - (COORD_W+1)'(i_end_y);
    assign init_dx    = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : (COORD_W+1)'(diff_x);
    assign init_dy    = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : (COORD_W+1)'(diff_y);
    assign init_steep = init_dy > init_dx;
    assign init_major = init_steep ? init_dy : init_dx;
    assign init_minor = init_steep ? init_dx : init_dy;

    // Current point: visibility and frame store address.
    logic [WALK_W-1:0] x_bits;
    logic [WALK_W-1:0] y_bits;
    logic              vis;
    logic [AW-1:0]     pix_addr;
    logic              pix_we;

    assign x_bits   = r_walk_x;
    assign y_bits   = r_walk_y;
    assign vis      = (r_walk_x >= 0) && (r_walk_y >= 0)
                   && (r_walk_x < WALK_W'(FB_WIDTH)) && (r_walk_y < WALK_W'(FB_HEIGHT));
    assign pix_addr = AW'(y_bits) * AW'(FB_WIDTH) + AW'(x_bits);
    assign pix_we   = i_cmd.wr_pix && vis && (r_op == OP_XOR || r_alpha != ALPHA_NONE);

    // New pixel value from the stored one.
    logic [CHAN_W-1:0] old_r;
    logic [CHAN_W-1:0] old_g;
    logic [CHAN_W-1:0] old_b;
    logic [LUMA_W-1:0] luma;
    logic [PIX_W-1:0]  blend_pix;
    logic [PIX_W-1:0]  new_pix;

    assign old_r = r_rdata[23:16];
    assign old_g = r_rdata[15:8];
    assign old_b = r_rdata[7:0];
    assign luma  = LUMA_W'(old_b) + LUMA_W'(old_g) + LUMA_W'({old_g, 1'b0})
                 + LUMA_W'({old_r, 1'b0});

    always_comb begin
        if (r_alpha == ALPHA_FULL) begin
            blend_pix = {r_red, r_green, r_blue};
        end else begin
            blend_pix = {blend_chan(r_alpha, r_red, old_r),
                         blend_chan(r_alpha, r_green, old_g),
                         blend_chan(r_alpha, r_blue, old_b)};
        end
        if (r_op == OP_XOR) begin
            new_pix = (luma < LUMA_LIMIT) ? GREY_LIGHT : GREY_DARK;
        end else begin
            new_pix = blend_pix;
        end
    end

    // Walker step: the minor axis moves when the error is not negative.
    logic signed [WALK_W-1:0] inc_x;
    logic signed [WALK_W-1:0] inc_y;
    logic                     err_ge;
    logic signed [WALK_W-1:0] n_walk_x;
    logic signed [WALK_W-1:0] n_walk_y;
    logic [ERR_W-1:0]         n_err;

    assign inc_x  = r_sx_neg ? '1 : WALK_W'(1);
    assign inc_y  = r_sy_neg ? '1 : WALK_W'(1);
    assign err_ge = !r_err[ERR_W-1];
    assign n_err  = r_err + r_minor4 - (err_ge ? r_major4 : '0);

    always_comb begin
        if (r_steep) begin
            n_walk_x = err_ge ? r_walk_x + inc_x : r_walk_x;
            n_walk_y = r_walk_y + inc_y;
        end else begin
            n_walk_x = r_walk_x + inc_x;
            n_walk_y = err_ge ? r_walk_y + inc_y : r_walk_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_opcode);
            r_red    <= i_red;
            r_green  <= i_green;
            r_blue   <= i_blue;
            r_alpha  <= i_alpha;
            r_walk_x <= WALK_W'(i_start_x);
            r_walk_y <= WALK_W'(i_start_y);
            r_err    <= ERR_W'({init_minor, 2'b00}) - ERR_W'(init_major);
            r_major4 <= ERR_W'({init_major, 2'b00});
            r_minor4 <= ERR_W'({init_minor, 2'b00});
            r_steps  <= CNT_W'(init_major) + CNT_W'(1);
            r_steep  <= init_steep;
            r_sx_neg <= !(i_start_x < i_end_x);
            r_sy_neg <= !(i_start_y < i_end_y);
            r_count  <= '0;
        end else if (i_cmd.wr_pix) begin
            r_walk_x <= n_walk_x;
            r_walk_y <= n_walk_y;
            r_err    <= n_err;
            r_steps  <= r_steps - CNT_W'(1);
            if (pix_we) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
        if (i_cmd.load_result) begin
            r_read_value <= (r_op == OP_READ && vis) ? r_rdata : '0;
            r_touched    <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= (r_clr_addr == LAST_ADDR) ? '0 : r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= '0;
        end else if (pix_we) begin
            r_mem[pix_addr] <= new_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_pix) begin
            r_rdata <= r_mem[pix_addr];
        end
    end

    assign o_sts.clr_last    = (r_clr_addr == LAST_ADDR);
    assign o_sts.last_step   = (r_steps == CNT_W'(1));
    assign o_read_value      = r_read_value;
    assign o_pixels_touched  = r_touched;

endmodule

### hdl/alpha_blend_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Alpha blend line rasterizer
// Draws blended or grey-marked lines into an RGB frame store, reads single
// pixels and clears the store.
// ----------------------------------------------------------------------------
// Channel   Handshake                  Payload
// request   i_in_valid / o_in_ready    i_opcode, i_start_x/y, i_end_x/y, i_red,
//                                      i_green, i_blue, i_alpha
// result    o_out_valid / i_out_ready  o_read_value, o_pixels_touched
//
// Each point of a line is one frame store read and one write through the
// single memory port pair.
// After reset a clearing pass runs with o_in_ready low.
// A request is taken while the previous result still waits in the output
// register; the block stalls only when it has a new result and that one is full.
// ----------------------------------------------------------------------------
module alpha_blend_line_rasterizer #(
    parameter int FB_WIDTH  = 256,
    parameter int FB_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [10:0] i_start_x,
    input  logic signed [10:0] i_start_y,
    input  logic signed [10:0] i_end_x,
    input  logic signed [10:0] i_end_y,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_alpha,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [23:0]        o_read_value,
    output logic [11:0]        o_pixels_touched
);
    import ablr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ablr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ablr_dpath #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_opcode         (i_opcode),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_alpha          (i_alpha),
        .o_read_value     (o_read_value),
        .o_pixels_touched (o_pixels_touched)
    );

endmodule

### test/alpha_blend_line_rasterizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha blend line rasterizer testbench
// Sends draw, grey-mark, read and clear requests through the valid/ready
// handshake and checks every result against a shadow frame store kept in
// the testbench. A short table of hand-picked requests comes first, then
// random requests that mostly hit a small corner of the screen so that
// lines overlap and blends work on pixels that already carry colour.
// ----------------------------------------------------------------------------
module alpha_blend_line_rasterizer_test;
    import ablr_pkg::*;

    localparam int FB_W            = 256;
    localparam int FB_H            = 256;
    localparam int RANDOM_REQUESTS = 267;
    localparam int DRAIN_CYCLES    = 16;

    typedef struct {
        t_op                op;
        logic signed [10:0] sx;
        logic signed [10:0] sy;
        logic signed [10:0] ex;
        logic signed [10:0] ey;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
    } t_request;

    typedef struct {
        logic [23:0] value;
        logic [11:0] touched;
    } t_pixel_result;

    typedef struct {
        t_request      req;
        bit            known;
        t_pixel_result result;
    } t_stimulus_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [1:0]         opcode = OP_READ;
    logic signed [10:0] start_x = '0;
    logic signed [10:0] start_y = '0;
    logic signed [10:0] end_x = '0;
    logic signed [10:0] end_y = '0;
    logic [7:0]         red = '0;
    logic [7:0]         green = '0;
    logic [7:0]         blue = '0;
    logic [7:0]         alpha = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [23:0]        read_value;
    logic [11:0]        pixels_touched;

    logic [23:0]     shadow_frame [0:FB_W*FB_H-1];
    t_pixel_result   expected_q [$];
    t_stimulus_row   stimulus_rows [$];
    int              failures = 0;
    int              sent_count = 0;
    int              received_count = 0;
    int              clears_left = 3;

    alpha_blend_line_rasterizer #(
        .FB_WIDTH (FB_W),
        .FB_HEIGHT(FB_H)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (req_valid),
        .o_in_ready      (req_ready),
        .i_opcode        (opcode),
        .i_start_x       (start_x),
        .i_start_y       (start_y),
        .i_end_x         (end_x),
        .i_end_y         (end_y),
        .i_red           (red),
        .i_green         (green),
        .i_blue          (blue),
        .i_alpha         (alpha),
        .o_out_valid     (res_valid),
        .i_out_ready     (res_ready),
        .o_read_value    (read_value),
        .o_pixels_touched(pixels_touched)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void wipe_frame();
        foreach (shadow_frame[i]) shadow_frame[i] = '0;
    endfunction

    function automatic bit on_screen(input int x, input int y);
        return x >= 0 && y >= 0 && x < FB_W && y < FB_H;
    endfunction

    function automatic logic [7:0] mix_channel(input int a, input int c, input int old);
        return 8'((a * c + (255 - a) * old) >> 8);
    endfunction

    // Walks the line exactly as the hardware does, updating the shadow store,
    // and returns the number of on-screen pixels written.
    function automatic logic [11:0] trace_line(input t_request req, input bit grey_mode);
        int          x;
        int          y;
        int          dx;
        int          dy;
        int          step_x;
        int          step_y;
        int          swap;
        int          err;
        int          steps;
        int          count;
        int          idx;
        int          luma;
        bit          steep;
        logic [23:0] old_pix;
        logic [23:0] new_pix;
        x      = req.sx;
        y      = req.sy;
        dx     = (req.sx > req.ex) ? int'(req.sx) - int'(req.ex) : int'(req.ex) - int'(req.sx);
        dy     = (req.sy > req.ey) ? int'(req.sy) - int'(req.ey) : int'(req.ey) - int'(req.sy);
        step_x = (req.sx < req.ex) ? 1 : -1;
        step_y = (req.sy < req.ey) ? 1 : -1;
        steep  = dy > dx;
        if (steep) begin
            swap = dx;
            dx   = dy;
            dy   = swap;
        end
        err   = 4 * dy - dx;
        steps = dx + 1;
        count = 0;
        while (steps != 0) begin
            if (on_screen(x, y) && (grey_mode || req.alpha != 8'd0)) begin
                idx     = y * FB_W + x;
                old_pix = shadow_frame[idx];
                if (grey_mode) begin
                    luma    = int'(old_pix[7:0]) + 3 * int'(old_pix[15:8])
                              + 2 * int'(old_pix[23:16]);
                    new_pix = (luma < int'(LUMA_LIMIT)) ? GREY_LIGHT : GREY_DARK;
                end else if (req.alpha == 8'd255) begin
                    new_pix = {req.red, req.green, req.blue};
                end else begin
                    new_pix = {mix_channel(req.alpha, req.red, old_pix[23:16]),
                               mix_channel(req.alpha, req.green, old_pix[15:8]),
                               mix_channel(req.alpha, req.blue, old_pix[7:0])};
                end
                shadow_frame[idx] = new_pix;
                count++;
            end
            if (err >= 0) begin
                if (steep) x += step_x;
                else y += step_y;
                err -= 4 * dx;
            end
            if (steep) y += step_y;
            else x += step_x;
            err += 4 * dy;
            steps--;
        end
        return 12'(count);
    endfunction

    function automatic t_pixel_result predict_request(input t_request req);
        t_pixel_result res;
        res.value   = '0;
        res.touched = '0;
        case (req.op)
            OP_DRAW: res.touched = trace_line(req, 1'b0);
            OP_XOR:  res.touched = trace_line(req, 1'b1);
            OP_READ: begin
                if (on_screen(req.sx, req.sy))
                    res.value = shadow_frame[int'(req.sy) * FB_W + int'(req.sx)];
            end
            default: wipe_frame();
        endcase
        return res;
    endfunction

    // Every fourth block of 24 requests runs without any idle cycles.
    function automatic int pick_gap(input int n);
        if ((n / 24) % 4 == 3) return 0;
        return $urandom_range(0, 5);
    endfunction

    task automatic add_row(input t_op op, input int sx, input int sy, input int ex,
                           input int ey, input logic [23:0] colour, input int a,
                           input bit known, input logic [23:0] value, input int touched);
        t_stimulus_row row;
        row.req.op         = op;
        row.req.sx         = 11'(sx);
        row.req.sy         = 11'(sy);
        row.req.ex         = 11'(ex);
        row.req.ey         = 11'(ey);
        row.req.red        = colour[23:16];
        row.req.green      = colour[15:8];
        row.req.blue       = colour[7:0];
        row.req.alpha      = 8'(a);
        row.known          = known;
        row.result.value   = value;
        row.result.touched = 12'(touched);
        stimulus_rows.push_back(row);
    endtask

    function automatic t_request random_request();
        t_request req;
        int       pick;
        int       x;
        int       y;
        pick = $urandom_range(0, 99);
        if (pick < 45) req.op = OP_DRAW;
        else if (pick < 65) req.op = OP_XOR;
        else if (pick < 98 || clears_left == 0) req.op = OP_READ;
        else begin
            req.op = OP_CLEAR;
            clears_left--;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            req.sx = 11'($urandom_range(0, 2047));
            req.sy = 11'($urandom_range(0, 2047));
            req.ex = 11'($urandom_range(0, 2047));
            req.ey = 11'($urandom_range(0, 2047));
        end else begin
            if (pick < 22) begin
                // Around the edges, so that lines run on and off the screen.
                x = $urandom_range(0, 1) ? $urandom_range(0, 24) - 12 : $urandom_range(243, 267);
                y = $urandom_range(0, 1) ? $urandom_range(0, 24) - 12 : $urandom_range(243, 267);
            end else begin
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
            end
            req.sx = 11'(x);
            req.sy = 11'(y);
            req.ex = 11'(x + $urandom_range(0, 40) - 20);
            req.ey = 11'(y + $urandom_range(0, 40) - 20);
        end
        req.red   = 8'($urandom);
        req.green = 8'($urandom);
        req.blue  = 8'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 20) req.alpha = 8'd0;
        else if (pick < 40) req.alpha = 8'd255;
        else req.alpha = 8'($urandom);
        return req;
    endfunction

    task automatic issue_request(input t_request req, input bit known,
                                 input t_pixel_result typed_result);
        int            gap;
        t_pixel_result res;
        gap = pick_gap(sent_count);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= req.op;
        start_x   <= req.sx;
        start_y   <= req.sy;
        end_x     <= req.ex;
        end_y     <= req.ey;
        red       <= req.red;
        green     <= req.green;
        blue      <= req.blue;
        alpha     <= req.alpha;
        do @(posedge clk); while (!req_ready);
        res = predict_request(req);
        expected_q.push_back(known ? typed_result : res);
        sent_count++;
    endtask

    initial begin : stimulus
        t_pixel_result none;
        none.value   = '0;
        none.touched = '0;
        wipe_frame();

        add_row(OP_READ, 0, 0, 0, 0, 24'h000000, 0, 1, 24'h000000, 0);
        add_row(OP_READ, 255, 255, 0, 0, 24'h000000, 0, 1, 24'h000000, 0);
        add_row(OP_DRAW, 10, 10, 10, 10, 24'hFF0000, 255, 1, 24'h000000, 1);
        add_row(OP_READ, 10, 10, 0, 0, 24'h000000, 0, 1, 24'hFF0000, 0);
        add_row(OP_DRAW, 0, 0, 20, 5, 24'hFFFFFF, 0, 1, 24'h000000, 0);
        add_row(OP_READ, 0, 0, 0, 0, 24'h000000, 0, 1, 24'h000000, 0);
        add_row(OP_DRAW, 10, 10, 10, 10, 24'h00FF00, 128, 0, 24'h000000, 0);
        add_row(OP_READ, 10, 10, 0, 0, 24'h000000, 0, 0, 24'h000000, 0);
        add_row(OP_XOR, 10, 10, 10, 10, 24'h000000, 0, 0, 24'h000000, 0);
        add_row(OP_XOR, 11, 11, 11, 11, 24'h000000, 0, 0, 24'h000000, 0);
        add_row(OP_READ, 11, 11, 0, 0, 24'h000000, 0, 1, 24'hC0C0C0, 0);
        add_row(OP_DRAW, 5, 0, 7, 30, 24'h123456, 255, 0, 24'h000000, 0);
        add_row(OP_DRAW, 40, 40, 0, 30, 24'hA5C37E, 200, 0, 24'h000000, 0);
        add_row(OP_DRAW, -1024, -1024, -1000, -1024, 24'hFFFFFF, 255, 1, 24'h000000, 0);
        add_row(OP_DRAW, -1024, -1024, 1023, 1023, 24'hFFFFFF, 255, 0, 24'h000000, 0);
        add_row(OP_XOR, 1023, -1024, -1024, 1023, 24'h000000, 0, 0, 24'h000000, 0);
        add_row(OP_READ, -1, 5, 0, 0, 24'h000000, 0, 1, 24'h000000, 0);
        add_row(OP_READ, 1023, 1023, -1024, -1024, 24'hFFFFFF, 255, 1, 24'h000000, 0);
        add_row(OP_READ, 100, 100, 0, 0, 24'h000000, 0, 0, 24'h000000, 0);
        add_row(OP_CLEAR, 0, 0, 0, 0, 24'h000000, 0, 1, 24'h000000, 0);
        add_row(OP_READ, 100, 100, 0, 0, 24'h000000, 0, 1, 24'h000000, 0);
        add_row(OP_DRAW, 250, 100, 300, 120, 24'h3C9F01, 255, 0, 24'h000000, 0);
        add_row(OP_DRAW, 0, 255, 255, 255, 24'hFFFFFF, 1, 0, 24'h000000, 0);
        add_row(OP_DRAW, 255, 255, 0, 255, 24'hFFFFFF, 254, 0, 24'h000000, 0);
        add_row(OP_READ, 255, 255, 0, 0, 24'h000000, 0, 0, 24'h000000, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stimulus_rows[i])
            issue_request(stimulus_rows[i].req, stimulus_rows[i].known, stimulus_rows[i].result);
        repeat (RANDOM_REQUESTS) issue_request(random_request(), 1'b0, none);
        req_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0) begin
            $display("alpha_blend_line_rasterizer_test OK");
        end else begin
            $display("alpha_blend_line_rasterizer_test NOT OK");
        end
        $finish;
    end

    initial begin : result_check
        int            gap;
        t_pixel_result exp;
        while (!rst_n) @(posedge clk);
        forever begin
            gap = pick_gap(received_count);
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            if (expected_q.size() == 0) begin
                $error("unexpected result: read_value %h pixels_touched %0d",
                       read_value, pixels_touched);
                failures++;
            end else begin
                exp = expected_q.pop_front();
                if (read_value !== exp.value) begin
                    $error("read_value: expected %h, got %h", exp.value, read_value);
                    failures++;
                end
                if (pixels_touched !== exp.touched) begin
                    $error("pixels_touched: expected %0d, got %0d",
                           exp.touched, pixels_touched);
                    failures++;
                end
            end
            received_count++;
        end
    end

    // The clearing pass after reset, each clear and a full-length line are the
    // longest operations; even with every request such a line under the
    // longest idle gaps the run stays several times below this limit.
    initial begin : watchdog
        #(64'd40_000_000);
        $display("alpha_blend_line_rasterizer_test NOT OK");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/ablr_pkg.sv
hdl/ablr_ctrl.sv
hdl/ablr_dpath.sv
hdl/alpha_blend_line_rasterizer.sv
test/alpha_blend_line_rasterizer_test.sv
